// File: hw/rtl/ffca_pkg.sv
`timescale 1ns / 1ps
package ffca_pkg;

   localparam int NUM_POOLS  = 4;
   localparam int POOL_BYTES = 65536;

   typedef enum logic [1:0] {
      OP_ALLOC    = 2'd0,
      OP_FREE     = 2'd1,
      OP_FREE_ALL = 2'd2,
      OP_BAD      = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_BAD    = 2'd1,
      ST_NOFIT  = 2'd2,
      ST_UNINIT = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [1:0]  pool_id;
      logic [15:0] req_bytes;
      logic [15:0] obj_offset;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] granted_offset;
      logic [16:0] granted_bytes;
      logic [16:0] free_bytes;
   } rsp_type;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_A_RD,
      S_A_CHK,
      S_A_SPLIT,
      S_A_HDR,
      S_A_UNLINK,
      S_F_RD,
      S_F_RDC,
      S_F_WALK_RD,
      S_F_WALK_CHK,
      S_F_NEXT_RD,
      S_F_NEXT_CHK,
      S_F_CUR_WR,
      S_F_PREV_RD,
      S_F_PREV_CHK,
      S_F_PREV_WR,
      S_DONE
   } state_type;

endpackage

// File: hw/rtl/ffca_ram.sv
`timescale 1ns / 1ps
module ffca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// File: hw/rtl/first_fit_coalescing_allocator_top.sv
`timescale 1ns / 1ps
// Channel   Ports                          Handshake
// request   req_*, start, busy             accepted when start && !busy
// response  rsp_*, rsp_valid               one-cycle strobe, cannot be stalled
// csr       csr_valid/ready/index/data     written when csr_valid && csr_ready
//
// A rejected request or a free-all goes from decode straight to done; allocate
// walks the free list cell by cell, then splits, writes the header and unlinks;
// free reads the freed cell, walks the list below it, then merges with the next
// and the previous cell. Each link followed through the single read port of the
// cell store costs one read and one registered compare.
// Reset: synchronous; heads and hints go to the null link, counts to zero.
// The cell store is not cleared; free-all initializes a pool.
// The response strobe cannot be stalled; busy stays high until it has been shown.
module first_fit_coalescing_allocator_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  ffca_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   output ffca_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ffca_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ffca_pkg::CSR_DATA_W-1:0]   csr_data
);
   import ffca_pkg::*;

   localparam int GRAN  = POOL_BYTES / 4;
   localparam int GW    = $clog2(GRAN) + 1;    // granule index plus null
   localparam int PW    = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
   localparam int AW    = $clog2(NUM_POOLS * GRAN);
   localparam int SW    = 17;
   localparam int CW    = $clog2(POOL_BYTES) + 1;
   localparam logic [GW-1:0] NIL = GW'(GRAN);
   localparam logic [SW-1:0] CAP = SW'(POOL_BYTES & ~3);
   localparam logic [CW-1:0] CNT_MAX = CW'(POOL_BYTES);

   // Configuration registers.
   logic [SW-1:0] pool_reg_ff [4];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) pool_reg_ff[i] <= '0;
      end else if (csr_valid && csr_ready) begin
         pool_reg_ff[csr_index] <= csr_data;
      end
   end
   assign csr_ready = 1'b1;

   // Per-pool state.
   logic [GW-1:0] head_ff [NUM_POOLS];
   logic [GW-1:0] hint_ff [NUM_POOLS];
   logic [CW-1:0] cnt_ff  [NUM_POOLS];

   // Cell store: size and link packed together, one shared read port.
   localparam int MW = SW + GW;
   logic          mem_we;
   logic [AW-1:0] mem_wa, mem_ra;
   logic [MW-1:0] mem_wd, mem_rd;

   ffca_ram #(.WIDTH(MW), .DEPTH(NUM_POOLS * GRAN)) u_cells (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_addr (mem_ra),
      .rd_data (mem_rd)
   );

   logic [SW-1:0] rd_size;
   logic [GW-1:0] rd_link;
   assign rd_size = mem_rd[MW-1:GW];
   assign rd_link = (mem_rd[GW-1:0] < NIL) ? mem_rd[GW-1:0] : NIL;

   state_type state_ff, state_in;
   req_type   req_ff;
   logic          accept;
   logic [PW-1:0] pool_ff;
   logic [SW-1:0] need_ff;
   logic [GW-1:0] cur_ff, cur_in, prev_ff, prev_in;
   logic [GW-1:0] blk_ff;      // freed cell
   logic [SW-1:0] c0_ff, c0_in;
   logic [SW-1:0] cs_ff, cs_in;
   logic [GW-1:0] nl_ff, nl_in;
   logic [GW-1:0] steps_ff, steps_in;
   logic [1:0]    status_ff, status_in;
   logic [15:0]   off_ff, off_in;
   logic [16:0]   gbytes_ff, gbytes_in;
   logic          rsp_valid_ff;
   // Size of the predecessor cell, kept while walking for the allocate unlink.
   logic [SW-1:0] prev_size_ff;

   // Working copies, updated by the sequencer actions.
   logic [GW-1:0] head_w, hint_w;
   logic [CW-1:0] cnt_w;
   logic          head_we, hint_we, cnt_we;

   assign accept = start && !busy;

   logic [SW-1:0] psz_cur;
   logic [SW-1:0] reg_sel;
   always_comb begin
      reg_sel = pool_reg_ff[req_ff.pool_id];
      reg_sel = reg_sel & ~SW'(3);
      psz_cur = (reg_sel > CAP) ? CAP : reg_sel;
   end

   function automatic logic [AW-1:0] addr(input logic [PW-1:0] p, input logic [GW-1:0] g);
      logic [AW:0] a;
      a = (AW+1)'(p) * (AW+1)'(GRAN) + (AW+1)'(g);
      return a[AW-1:0];
   endfunction

   logic [GW-1:0] head_p, hint_p;
   logic [CW-1:0] cnt_p;
   assign head_p = head_ff[pool_ff];
   assign hint_p = hint_ff[pool_ff];
   assign cnt_p  = cnt_ff[pool_ff];

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (accept) state_in = S_DECODE;
         S_DECODE: begin
            if (req_ff.op == OP_BAD || 32'(req_ff.pool_id) >= NUM_POOLS) state_in = S_DONE;
            else if (psz_cur < SW'(8)) state_in = S_DONE;
            else if (req_ff.op == OP_ALLOC)
               state_in = (req_ff.req_bytes == '0) ? S_DONE : S_A_RD;
            else if (req_ff.op == OP_FREE) begin
               if (req_ff.obj_offset[1:0] != 2'd0 || req_ff.obj_offset < 16'd4 ||
                   SW'((req_ff.obj_offset - 16'd4) >> 2) >= (psz_cur >> 2))
                  state_in = S_DONE;
               else state_in = S_F_RD;
            end else state_in = S_DONE;
         end
         S_A_RD:   state_in = (cur_ff < NIL && steps_ff <= GW'(GRAN)) ? S_A_CHK : S_DONE;
         S_A_CHK:  state_in = (need_ff <= rd_size) ? S_A_SPLIT : S_A_RD;
         S_A_SPLIT: state_in = S_A_HDR;
         S_A_HDR:   state_in = S_A_UNLINK;
         S_A_UNLINK: state_in = S_DONE;
         S_F_RD:   state_in = S_F_RDC;
         S_F_RDC:  state_in = S_F_WALK_RD;
         S_F_WALK_RD: state_in = (cur_ff < NIL && cur_ff < blk_ff && steps_ff <= GW'(GRAN))
                                 ? S_F_WALK_CHK : S_F_NEXT_RD;
         S_F_WALK_CHK: state_in = S_F_WALK_RD;
         S_F_NEXT_RD:  state_in = S_F_NEXT_CHK;
         S_F_NEXT_CHK: state_in = S_F_CUR_WR;
         S_F_CUR_WR:   state_in = S_F_PREV_RD;
         S_F_PREV_RD:  state_in = S_F_PREV_CHK;
         S_F_PREV_CHK: state_in = S_F_PREV_WR;
         S_F_PREV_WR:  state_in = S_DONE;
         S_DONE:   state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      logic [GW:0] rest;
      cur_in = cur_ff; prev_in = prev_ff; c0_in = c0_ff; cs_in = cs_ff; nl_in = nl_ff;
      steps_in = steps_ff; status_in = status_ff; off_in = off_ff; gbytes_in = gbytes_ff;
      mem_we = 1'b0; mem_wa = addr(pool_ff, cur_ff); mem_wd = '0;
      mem_ra = addr(pool_ff, cur_ff);
      head_w = head_p; hint_w = hint_p; cnt_w = cnt_p;
      head_we = 1'b0; hint_we = 1'b0; cnt_we = 1'b0;
      rest = (GW+1)'(cur_ff) + (GW+1)'(need_ff >> 2);
      unique case (state_ff)
         S_DECODE: begin
            status_in = ST_OK; off_in = '0; gbytes_in = '0;
            steps_in = '0; prev_in = NIL;
            cur_in = head_ff[req_ff.pool_id[PW-1:0]];
            if (req_ff.op == OP_BAD || 32'(req_ff.pool_id) >= NUM_POOLS) status_in = ST_BAD;
            else if (psz_cur < SW'(8)) status_in = ST_UNINIT;
            else if (req_ff.op == OP_ALLOC) begin
               if (req_ff.req_bytes == '0) status_in = ST_BAD;
            end else if (req_ff.op == OP_FREE) begin
               if (req_ff.obj_offset[1:0] != 2'd0 || req_ff.obj_offset < 16'd4 ||
                   SW'((req_ff.obj_offset - 16'd4) >> 2) >= (psz_cur >> 2))
                  status_in = ST_BAD;
            end else begin
               mem_we = 1'b1;
               mem_wa = addr(PW'(req_ff.pool_id), '0);
               mem_wd = {psz_cur, NIL};
            end
         end
         S_A_RD: begin
            mem_ra = addr(pool_ff, cur_ff);
            if (!(cur_ff < NIL && steps_ff <= GW'(GRAN))) status_in = ST_NOFIT;
         end
         S_A_CHK: begin
            if (need_ff <= rd_size) begin
               cs_in = rd_size; nl_in = rd_link;
            end else begin
               prev_in = cur_ff; cur_in = rd_link; steps_in = steps_ff + 1'b1;
            end
         end
         S_A_SPLIT: begin
            if (cs_ff >= need_ff + SW'(8) && rest < (GW+1)'(GRAN)) begin
               mem_we = 1'b1;
               mem_wa = addr(pool_ff, rest[GW-1:0]);
               mem_wd = {cs_ff - need_ff, nl_ff};
               cs_in = need_ff;
               nl_in = rest[GW-1:0];
            end
         end
         S_A_HDR: begin
            // The taken cell keeps its granted size for the later free.
            mem_we = 1'b1; mem_wa = addr(pool_ff, cur_ff); mem_wd = {cs_ff, nl_ff};
         end
         S_A_UNLINK: begin
            if (prev_ff == NIL) begin
               head_w = nl_ff; head_we = 1'b1;
            end else begin
               mem_we = 1'b1; mem_wa = addr(pool_ff, prev_ff);
               mem_wd = {prev_size_ff, nl_ff};
            end
            if (hint_p == cur_ff) begin hint_w = NIL; hint_we = 1'b1; end
            cnt_w = (cnt_p > CW'(cs_ff)) ? cnt_p - CW'(cs_ff) : '0; cnt_we = 1'b1;
            off_in = 16'(cur_ff * 4 + 4);
            gbytes_in = cs_ff;
         end
         S_F_RD: begin
            mem_ra = addr(pool_ff, blk_ff);
            cur_in = (hint_p < NIL && hint_p < blk_ff) ? hint_p : head_p;
            prev_in = NIL; steps_in = '0;
         end
         S_F_RDC: begin
            c0_in = rd_size;
            mem_ra = addr(pool_ff, cur_ff);
         end
         S_F_WALK_RD: mem_ra = addr(pool_ff, cur_ff);
         S_F_WALK_CHK: begin
            prev_in = cur_ff; cur_in = rd_link; steps_in = steps_ff + 1'b1;
         end
         S_F_NEXT_RD: begin
            if (cur_ff < NIL && cur_ff < blk_ff) cur_in = NIL;
            mem_ra = addr(pool_ff, (cur_ff < blk_ff) ? NIL : cur_ff);
         end
         S_F_NEXT_CHK: begin
            cs_in = rd_size; nl_in = rd_link;
         end
         S_F_CUR_WR: begin
            mem_we = 1'b1; mem_wa = addr(pool_ff, blk_ff);
            if (cur_ff < NIL) begin
               if ((GW+SW)'(blk_ff) * 4 + (GW+SW)'(c0_ff) == (GW+SW)'(cur_ff) * 4)
                  mem_wd = {c0_ff + cs_ff, nl_ff};
               else mem_wd = {c0_ff, cur_ff};
            end else mem_wd = {c0_ff, NIL};
            nl_in = mem_wd[GW-1:0]; cs_in = mem_wd[MW-1:GW];
            hint_w = blk_ff; hint_we = 1'b1;
         end
         S_F_PREV_RD:  mem_ra = addr(pool_ff, prev_ff);
         S_F_PREV_CHK: mem_ra = addr(pool_ff, prev_ff);
         S_F_PREV_WR: begin
            if (prev_ff < NIL) begin
               mem_we = 1'b1; mem_wa = addr(pool_ff, prev_ff);
               if ((GW+SW)'(prev_ff) * 4 + (GW+SW)'(rd_size) == (GW+SW)'(blk_ff) * 4) begin
                  mem_wd = {rd_size + cs_ff, nl_ff};
                  hint_w = prev_ff; hint_we = 1'b1;
               end else mem_wd = {rd_size, blk_ff};
            end else begin
               head_w = blk_ff; head_we = 1'b1;
               hint_w = NIL; hint_we = 1'b1;
            end
            cnt_w = ((CW+1)'(cnt_p) + (CW+1)'(c0_ff) > (CW+1)'(CNT_MAX)) ? CNT_MAX
                    : CW'(cnt_p + CW'(c0_ff));
            cnt_we = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_A_CHK && !(need_ff <= rd_size)) prev_size_ff <= rd_size;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_POOLS; i++) begin
            head_ff[i] <= NIL; hint_ff[i] <= NIL; cnt_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == S_DONE);
         if (state_ff == S_DECODE && status_in == ST_OK && req_ff.op == OP_FREE_ALL) begin
            head_ff[req_ff.pool_id[PW-1:0]] <= '0;
            hint_ff[req_ff.pool_id[PW-1:0]] <= NIL;
            cnt_ff[req_ff.pool_id[PW-1:0]]  <= CW'(psz_cur);
         end
         if (head_we) head_ff[pool_ff] <= head_w;
         if (hint_we) hint_ff[pool_ff] <= hint_w;
         if (cnt_we)  cnt_ff[pool_ff]  <= cnt_w;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) req_ff <= req_data;
      if (state_ff == S_DECODE) begin
         pool_ff <= req_ff.pool_id[PW-1:0];
         need_ff <= SW'((18'(req_ff.req_bytes) + 18'd7) & ~18'd3);
         blk_ff  <= GW'((req_ff.obj_offset - 16'd4) >> 2);
      end
      cur_ff <= cur_in; prev_ff <= prev_in; c0_ff <= c0_in; cs_ff <= cs_in; nl_ff <= nl_in;
      steps_ff <= steps_in; status_ff <= status_in; off_ff <= off_in; gbytes_ff <= gbytes_in;
   end

   assign busy      = (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   always_comb begin
      rsp_data.status         = status_ff;
      rsp_data.granted_offset = off_ff;
      rsp_data.granted_bytes  = gbytes_ff;
      rsp_data.free_bytes     = (req_ff.op == OP_BAD || 32'(req_ff.pool_id) >= NUM_POOLS)
                                ? '0 : 17'(cnt_ff[req_ff.pool_id[PW-1:0]]);
   end
endmodule

// File: hw/rtl/ffca_checker.sv
`timescale 1ns / 1ps
module ffca_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised after start");
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response strobe longer than one cycle");
   a_busy_with_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("idle while response shown");
   a_no_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !rsp_valid) else $error("response without request");
endmodule

bind first_fit_coalescing_allocator_top ffca_checker u_ffca_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .rsp_valid(rsp_valid)
);

// File: bench/first_fit_coalescing_allocator_top_tb.sv
`timescale 1ns / 1ps
module first_fit_coalescing_allocator_top_tb;
   import ffca_pkg::*;

   // Keeps a private copy of every pool's free list and predicts each response.
   class pool_scoreboard;
      localparam int unsigned NPOOL = 4;
      localparam int unsigned CAP   = 65536;
      localparam int unsigned GRAN  = CAP / 4;
      localparam int unsigned NIL   = GRAN;

      int unsigned pool_reg[NPOOL];
      int unsigned cell_size[NPOOL * GRAN];
      int unsigned cell_link[NPOOL * GRAN];
      bit          written[NPOOL * GRAN];
      int unsigned head[NPOOL];
      int unsigned hint[NPOOL];
      int unsigned free_cnt[NPOOL];
      rsp_type     pending_rsp[$];
      int          errors;

      function new();
         for (int i = 0; i < NPOOL; i++) begin
            pool_reg[i] = 0;
            head[i] = NIL;
            hint[i] = NIL;
            free_cnt[i] = 0;
         end
         errors = 0;
      endfunction

      function int unsigned rd_size(int unsigned p, int unsigned g);
         return cell_size[p * GRAN + g] & 32'h1FFFF;
      endfunction

      function int unsigned rd_link(int unsigned p, int unsigned g);
         int unsigned v;
         v = cell_link[p * GRAN + g];
         return (v < GRAN) ? v : NIL;
      endfunction

      function void wr_size(int unsigned p, int unsigned g, int unsigned v);
         cell_size[p * GRAN + g] = v & 32'h1FFFF;
         written[p * GRAN + g] = 1'b1;
      endfunction

      function void wr_link(int unsigned p, int unsigned g, int unsigned v);
         cell_link[p * GRAN + g] = (v < GRAN) ? v : NIL;
      endfunction

      function int unsigned pool_size(int unsigned p);
         int unsigned r;
         r = pool_reg[p] & ~32'd3;
         return (r > CAP) ? CAP : r;
      endfunction

      // First fit over the address-ordered list, splitting off the tail when
      // at least one minimum cell would be left over.
      function status_type alloc_cell(int unsigned p, int unsigned req,
                                      output int unsigned off, output int unsigned bytes);
         int unsigned need, prev, cur, steps, cs, nl, rest;
         bit found;
         need = (req + 4 + 3) & ~32'd3;
         prev = NIL;
         cur = head[p];
         steps = 0;
         found = 0;
         off = 0;
         bytes = 0;
         while (cur < GRAN && steps <= GRAN) begin
            if (need <= rd_size(p, cur)) begin
               found = 1;
               break;
            end
            prev = cur;
            cur = rd_link(p, cur);
            steps++;
         end
         if (!found) return ST_NOFIT;
         cs = rd_size(p, cur);
         nl = rd_link(p, cur);
         if (cs >= need + 8) begin
            rest = cur + need / 4;
            if (rest < GRAN) begin
               wr_size(p, rest, cs - need);
               wr_link(p, rest, nl);
               wr_size(p, cur, need);
               wr_link(p, cur, rest);
               cs = need;
               nl = rest;
            end
         end
         if (prev == NIL) head[p] = nl;
         else wr_link(p, prev, nl);
         if (hint[p] == cur) hint[p] = NIL;
         free_cnt[p] = (free_cnt[p] > cs) ? free_cnt[p] - cs : 0;
         off = (cur * 4 + 4) & 32'hFFFF;
         bytes = cs & 32'h1FFFF;
         return ST_OK;
      endfunction

      // Returns a cell to the list, merging with the next and previous cells.
      function void release_cell(int unsigned p, int unsigned cur);
         int unsigned c0, nf, pf, steps, ps, s;
         c0 = rd_size(p, cur);
         nf = head[p];
         pf = NIL;
         steps = 0;
         if (hint[p] < GRAN && hint[p] < cur) nf = hint[p];
         while (nf < GRAN && nf < cur && steps <= GRAN) begin
            pf = nf;
            nf = rd_link(p, nf);
            steps++;
         end
         if (nf < GRAN && nf < cur) nf = NIL;
         if (nf < GRAN) begin
            if (cur * 4 + c0 == nf * 4) begin
               wr_size(p, cur, c0 + rd_size(p, nf));
               wr_link(p, cur, rd_link(p, nf));
            end else begin
               wr_link(p, cur, nf);
            end
         end else begin
            wr_link(p, cur, NIL);
         end
         hint[p] = cur;
         if (pf < GRAN) begin
            ps = rd_size(p, pf);
            if (pf * 4 + ps == cur * 4) begin
               wr_size(p, pf, ps + rd_size(p, cur));
               wr_link(p, pf, rd_link(p, cur));
               hint[p] = pf;
            end else begin
               wr_link(p, pf, cur);
            end
         end else begin
            head[p] = cur;
            hint[p] = NIL;
         end
         s = free_cnt[p] + c0;
         free_cnt[p] = (s > CAP) ? CAP : s;
      endfunction

      // Notes an accepted request and queues the response it must produce.
      function rsp_type note(req_type r);
         rsp_type     e;
         int unsigned p, psz, obj, off, bytes;
         p = r.pool_id;
         obj = r.obj_offset;
         off = 0;
         bytes = 0;
         e = '0;
         if (op_type'(r.op) == OP_BAD) begin
            e.status = ST_BAD;
         end else begin
            psz = pool_size(p);
            if (psz < 8) begin
               e.status = ST_UNINIT;
            end else begin
               case (op_type'(r.op))
                  OP_ALLOC: begin
                     if (r.req_bytes == 0) e.status = ST_BAD;
                     else e.status = alloc_cell(p, r.req_bytes, off, bytes);
                  end
                  OP_FREE: begin
                     if ((obj & 3) != 0 || obj < 4 || (obj - 4) / 4 >= psz / 4)
                        e.status = ST_BAD;
                     else begin
                        release_cell(p, (obj - 4) / 4);
                        e.status = ST_OK;
                     end
                  end
                  default: begin
                     head[p] = 0;
                     wr_size(p, 0, psz);
                     wr_link(p, 0, NIL);
                     hint[p] = NIL;
                     free_cnt[p] = psz;
                     e.status = ST_OK;
                  end
               endcase
            end
            // An uninitialized pool still reports its running count.
            e.free_bytes = 17'(free_cnt[p]);
         end
         e.granted_offset = 16'(off);
         e.granted_bytes = 17'(bytes);
         pending_rsp.push_back(e);
         return e;
      endfunction

      task report(string msg);
         $display("ERROR: %s", msg);
         errors++;
      endtask

      task check(rsp_type got);
         rsp_type e;
         if (pending_rsp.size() == 0) begin
            report("response with no request outstanding");
            return;
         end
         e = pending_rsp.pop_front();
         if (got.status !== e.status)
            report($sformatf("status %0d, predicted %0d", got.status, e.status));
         if (got.granted_offset !== e.granted_offset)
            report($sformatf("granted_offset %0d, predicted %0d",
                             got.granted_offset, e.granted_offset));
         if (got.granted_bytes !== e.granted_bytes)
            report($sformatf("granted_bytes %0d, predicted %0d",
                             got.granted_bytes, e.granted_bytes));
         if (got.free_bytes !== e.free_bytes)
            report($sformatf("free_bytes %0d, predicted %0d", got.free_bytes, e.free_bytes));
      endtask
   endclass

   // A walk over a broken list may take one step per granule on every request;
   // a stuck handshake trips this well after that worst case.
   localparam int LIMIT = 200000000;
   localparam int GRAN  = 16384;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   pool_scoreboard sb = new();
   int             cycles = 0;
   bit             idling_on = 1'b1;
   // Object offsets currently handed out, per pool, so that most frees are legal.
   int unsigned    live[4][$];

   first_fit_coalescing_allocator_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Every response is taken in the cycle it appears; the receiver never stalls.
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check(rsp_data);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("first_fit_coalescing_allocator_top: mismatch");
         $finish;
      end
   end

   // Presents one request and returns once it is accepted. Start is left high
   // so back-to-back requests need no low cycle; a random idle gap or the caller lowers it.
   task automatic send_request(req_type r);
      rsp_type e;
      @(negedge clock);
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      e = sb.note(r);
      // Keep the list of live objects in step with the predicted outcome.
      if (op_type'(r.op) == OP_ALLOC && e.status == ST_OK)
         live[r.pool_id].push_back(e.granted_offset);
      if (op_type'(r.op) == OP_FREE_ALL && e.status == ST_OK)
         live[r.pool_id].delete();
      if (idling_on && $urandom_range(0, 99) < 28) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(0, 5)) @(negedge clock);
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      // Let the final response strobe and busy settle before touching the CSRs.
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(int idx, int unsigned value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_IDX_W'(idx);
      csr_data <= CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_ready);
      sb.pool_reg[idx] = value & 32'h1FFFF;
      live[idx].delete();
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic req_type make_req(op_type op, int unsigned p,
                                        int unsigned nbytes, int unsigned obj);
      req_type r;
      r.op = op;
      r.pool_id = 2'(p);
      r.req_bytes = 16'(nbytes);
      r.obj_offset = 16'(obj);
      return r;
   endfunction

   // Random request: mostly well-formed allocate/free traffic against live
   // objects, with some free-all, illegal opcodes and malformed offsets.
   function automatic req_type random_req();
      int unsigned p, sel, sz, idx, obj, g;
      req_type     r;
      p = $urandom_range(0, 3);
      sel = $urandom_range(0, 99);
      if (live[p].size() > 48 && sel < 44) sel = 60;
      if (sel < 44) begin
         sz = $urandom_range(0, 99);
         if (sz < 70) sz = $urandom_range(1, 32);
         else if (sz < 90) sz = $urandom_range(33, 512);
         else if (sz < 97) sz = $urandom_range(513, 8192);
         else sz = $urandom_range(0, 65535);
         r = make_req(OP_ALLOC, p, sz, $urandom_range(0, 65535));
      end else if (sel < 84 && live[p].size() > 0) begin
         idx = $urandom_range(0, live[p].size() - 1);
         obj = live[p][idx];
         live[p].delete(idx);
         r = make_req(OP_FREE, p, $urandom_range(0, 65535), obj);
      end else if (sel < 87) begin
         r = make_req(OP_FREE_ALL, p, $urandom_range(0, 65535), $urandom_range(0, 65535));
      end else begin
         sz = $urandom_range(0, 2);
         obj = $urandom_range(0, 65535);
         if (sz == 0) begin
            r = make_req(OP_BAD, p, $urandom_range(0, 65535), obj);
         end else if (sz == 1) begin
            r = make_req(OP_ALLOC, p, 0, obj);
         end else begin
            // A well-formed offset whose header was never stored must not be
            // freed; knock it out of alignment instead.
            g = (obj - 4) / 4;
            if ((obj & 3) == 0 && obj >= 4 && g < sb.pool_size(p) / 4 &&
                !sb.written[p * GRAN + g])
               obj = obj | 1;
            r = make_req(OP_FREE, p, $urandom_range(0, 65535), obj);
         end
      end
      return r;
   endfunction

   task automatic configure(int unsigned s0, int unsigned s1, int unsigned s2, int unsigned s3);
      wait_idle();
      csr_write(0, s0);
      csr_write(1, s1);
      csr_write(2, s2);
      csr_write(3, s3);
      for (int p = 0; p < 4; p++)
         send_request(make_req(OP_FREE_ALL, p, 0, 0));
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. Pool 0 holds a single minimum cell, pool 1 the full
      // range, pool 2 stays uninitialized and pool 3 is over-sized and capped.
      configure(8, 65536, 0, 131071);
      send_request(make_req(OP_ALLOC, 0, 1, 0));        // whole cell, no split
      send_request(make_req(OP_ALLOC, 0, 1, 0));        // nothing left to fit
      send_request(make_req(OP_FREE, 0, 0, 4));
      send_request(make_req(OP_FREE, 0, 0, 4));         // the same cell again
      send_request(make_req(OP_FREE, 0, 0, 12));        // cell past the pool end
      send_request(make_req(OP_FREE_ALL, 0, 0, 0));     // repairs the list
      send_request(make_req(OP_ALLOC, 1, 0, 0));        // zero-byte request
      send_request(make_req(OP_ALLOC, 1, 65535, 0));    // larger than the pool
      send_request(make_req(OP_ALLOC, 1, 65532, 0));    // exactly the whole pool
      send_request(make_req(OP_FREE, 1, 0, 4));
      send_request(make_req(OP_ALLOC, 1, 65524, 0));    // split leaves one minimum cell
      send_request(make_req(OP_FREE, 1, 0, 4));
      send_request(make_req(OP_FREE, 1, 0, 2));         // misaligned offset
      send_request(make_req(OP_FREE, 1, 0, 0));         // offset below the header
      send_request(make_req(OP_BAD, 1, 16'hFFFF, 16'hFFFF));
      send_request(make_req(OP_ALLOC, 2, 4, 0));        // uninitialized pool
      send_request(make_req(OP_FREE_ALL, 2, 0, 0));
      // Three neighbors: free both ends, then the middle merges all three.
      send_request(make_req(OP_ALLOC, 3, 4, 0));
      send_request(make_req(OP_ALLOC, 3, 4, 0));
      send_request(make_req(OP_ALLOC, 3, 4, 0));
      send_request(make_req(OP_FREE, 3, 0, 4));
      send_request(make_req(OP_FREE, 3, 0, 20));
      send_request(make_req(OP_FREE, 3, 0, 12));
      live[3].delete();

      // Random phases over a spread of pool sizes, the extremes included.
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: configure(65536, 4096, 1024, 512);
            1: configure(7, 65532, 65535, 9);
            2: configure($urandom_range(0, 131071), $urandom_range(8, 2048),
                         $urandom_range(0, 16384), $urandom_range(64, 65536));
            3: configure(4, 131071, 256, 12);
            default: configure($urandom_range(8, 4096), $urandom_range(8, 4096),
                               65536, $urandom_range(0, 131071));
         endcase
         // One phase runs with the sender never pausing.
         idling_on = (ph != 2);
         for (int n = 0; n < 340; n++)
            send_request(random_req());
      end

      @(negedge clock);
      start <= 1'b0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      if (sb.pending_rsp.size() != 0)
         sb.report("responses still outstanding at the end");
      if (sb.errors == 0) begin
         $display("first_fit_coalescing_allocator_top: match");
      end else begin
         $display("first_fit_coalescing_allocator_top: mismatch");
      end
      $finish;
   end
endmodule

// File: filelist.f
hw/rtl/ffca_pkg.sv
hw/rtl/ffca_ram.sv
hw/rtl/first_fit_coalescing_allocator_top.sv
hw/rtl/ffca_checker.sv
bench/first_fit_coalescing_allocator_top_tb.sv
